// ===== sv/tbcl_pkg.sv =====
// Shared constants for the texture box corner locator.
package tbcl_pkg;

  localparam logic [1:0] CFG_LEFT_U   = 2'd0;
  localparam logic [1:0] CFG_TOP_V    = 2'd1;
  localparam logic [1:0] CFG_RIGHT_U  = 2'd2;
  localparam logic [1:0] CFG_BOTTOM_V = 2'd3;

  localparam logic [1:0] SLOT_FIRST    = 2'd0;
  localparam logic [1:0] SLOT_SECOND   = 2'd1;
  localparam logic [1:0] SLOT_COMPLETE = 2'd2;
  localparam logic [1:0] SLOT_UNUSED   = 2'd3;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

endpackage

// ===== sv/tbcl_queue.sv =====
// Two-entry queue of complete triangles between the front and back parts.
module tbcl_queue #(
  parameter int DATA_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] head_data,
  output logic                  full,
  output logic                  empty
);

  logic [DATA_WIDTH-1:0] mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;

  assign full      = (count == 2'd2);
  assign empty     = (count == 2'd0);
  assign head_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== sv/tbcl_front.sv =====
// Front part: holds the first two vertices and queues triangles that touch the box span.
module tbcl_front import tbcl_pkg::*; #(
  parameter int POS_WIDTH     = 32,
  parameter int TEX_FRAC_BITS = 16,
  parameter int ENTRY_WIDTH   = 9 * POS_WIDTH + 6 * (TEX_FRAC_BITS + 1)
) (
  input  logic                     clk,
  input  logic                     accept,
  input  logic [1:0]               vertex_slot,
  input  logic [POS_WIDTH-1:0]     pos_x,
  input  logic [POS_WIDTH-1:0]     pos_y,
  input  logic [POS_WIDTH-1:0]     pos_z,
  input  logic [TEX_FRAC_BITS:0]   tex_u,
  input  logic [TEX_FRAC_BITS:0]   tex_v,
  input  logic [TEX_FRAC_BITS:0]   box_left_u,
  input  logic [TEX_FRAC_BITS:0]   box_right_u,
  output logic                     push,
  output logic [ENTRY_WIDTH-1:0]   push_data
);

  logic [POS_WIDTH-1:0]   held_position [6];
  logic [TEX_FRAC_BITS:0] held_texcoord [4];
  logic                   hit;

  always_ff @(posedge clk) begin
    if (accept && (vertex_slot == SLOT_FIRST)) begin
      held_position[0] <= pos_x;
      held_position[1] <= pos_y;
      held_position[2] <= pos_z;
      held_texcoord[0] <= tex_u;
      held_texcoord[1] <= tex_v;
    end
    if (accept && (vertex_slot == SLOT_SECOND)) begin
      held_position[3] <= pos_x;
      held_position[4] <= pos_y;
      held_position[5] <= pos_z;
      held_texcoord[2] <= tex_u;
      held_texcoord[3] <= tex_v;
    end
  end

  assign hit = (held_texcoord[0] >= box_left_u && held_texcoord[0] <= box_right_u) ||
               (held_texcoord[2] >= box_left_u && held_texcoord[2] <= box_right_u) ||
               (tex_u >= box_left_u && tex_u <= box_right_u);

  assign push = accept && (vertex_slot == SLOT_COMPLETE) && hit;

  assign push_data = {tex_v, tex_u, held_texcoord[3], held_texcoord[2],
                      held_texcoord[1], held_texcoord[0],
                      pos_z, pos_y, pos_x,
                      held_position[5], held_position[4], held_position[3],
                      held_position[2], held_position[1], held_position[0]};

endmodule

// ===== sv/tbcl_back.sv =====
// Back part: barycentric test, weight division and interpolation for each box corner.
module tbcl_back import tbcl_pkg::*; #(
  parameter int POS_WIDTH     = 32,
  parameter int TEX_FRAC_BITS = 16,
  parameter int ENTRY_WIDTH   = 9 * POS_WIDTH + 6 * (TEX_FRAC_BITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [ENTRY_WIDTH-1:0]      q_data,
  output logic                        q_pop,
  input  logic [TEX_FRAC_BITS:0]      box_left_u,
  input  logic [TEX_FRAC_BITS:0]      box_top_v,
  input  logic [TEX_FRAC_BITS:0]      box_right_u,
  input  logic [TEX_FRAC_BITS:0]      box_bottom_v,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [POS_WIDTH-1:0]        corner_x,
  output logic [POS_WIDTH-1:0]        corner_y,
  output logic [POS_WIDTH-1:0]        corner_z,
  output logic [1:0]                  corner_index,
  output logic                        last_of_triangle
);

  localparam int TB  = TEX_FRAC_BITS + 1;
  localparam int DFW = TB + 1;
  localparam int NW  = 2 * DFW + 2;
  localparam int W   = 62 - POS_WIDTH;
  localparam int AW  = W + POS_WIDTH + 3;
  localparam int CW  = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_LAST = CW'(W);
  localparam logic signed [AW-1:0] MAXV = $signed((AW'(1) << (POS_WIDTH - 1)) - AW'(1));
  localparam logic signed [AW-1:0] MINV = -MAXV - $signed(AW'(1));
  localparam logic signed [AW-1:0] RND  = $signed(AW'(1) << (W - 1));

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_PROD  = 10'b0000000010,
    ST_DET   = 10'b0000000100,
    ST_N1    = 10'b0000001000,
    ST_N2    = 10'b0000010000,
    ST_CHECK = 10'b0000100000,
    ST_DIV   = 10'b0001000000,
    ST_MUL   = 10'b0010000000,
    ST_FIN   = 10'b0100000000,
    ST_FLUSH = 10'b1000000000
  } state_t;

  state_t state;

  logic [TB-1:0]               tu [3];
  logic [TB-1:0]               tv [3];
  logic signed [POS_WIDTH-1:0] pp [9];
  logic signed [NW-1:0]        m1;
  logic signed [NW-1:0]        m2;
  logic signed [NW-1:0]        det;
  logic signed [NW-1:0]        n1;
  logic signed [NW-1:0]        n2;
  logic [NW:0]                 dd_r;
  logic [NW:0]                 r1;
  logic [NW:0]                 r2;
  logic [W:0]                  w1;
  logic [W:0]                  w2;
  logic [CW-1:0]               cnt;
  logic [1:0]                  k;
  logic signed [AW-1:0]        acc [3];
  logic                        pend_valid;
  logic [POS_WIDTH-1:0]        pend_pos [3];
  logic [1:0]                  pend_k;

  logic signed [DFW-1:0] ca, cb, cc, cd, dx, dy;
  logic [TB-1:0]         cu_k, cv_k;
  logic                  det_neg;
  logic signed [NW-1:0]  nn1, nn2, dd;
  logic signed [NW+1:0]  n3;
  logic                  corner_ok;
  logic                  ge1, ge2;
  logic [NW:0]           sub1, sub2;
  logic signed [AW-1:0]  ex [9];
  logic signed [AW-1:0]  acc_next [3];
  logic signed [AW-1:0]  sum [3];
  logic signed [AW-1:0]  quo [3];
  logic [POS_WIDTH-1:0]  res [3];
  logic                  out_free;
  logic                  out_load;

  assign ca = $signed({1'b0, tv[1]}) - $signed({1'b0, tv[2]});
  assign cb = $signed({1'b0, tu[2]}) - $signed({1'b0, tu[1]});
  assign cc = $signed({1'b0, tv[2]}) - $signed({1'b0, tv[0]});
  assign cd = $signed({1'b0, tu[0]}) - $signed({1'b0, tu[2]});

  always_comb begin
    unique case (k)
      CORNER_TL: begin cu_k = box_left_u;  cv_k = box_top_v;    end
      CORNER_TR: begin cu_k = box_right_u; cv_k = box_top_v;    end
      CORNER_BR: begin cu_k = box_right_u; cv_k = box_bottom_v; end
      CORNER_BL: begin cu_k = box_left_u;  cv_k = box_bottom_v; end
      default:   begin cu_k = box_left_u;  cv_k = box_top_v;    end
    endcase
  end

  assign dx = $signed({1'b0, cu_k}) - $signed({1'b0, tu[2]});
  assign dy = $signed({1'b0, cv_k}) - $signed({1'b0, tv[2]});

  assign det_neg   = det[NW-1];
  assign nn1       = det_neg ? -n1 : n1;
  assign nn2       = det_neg ? -n2 : n2;
  assign dd        = det_neg ? -det : det;
  assign n3        = (NW+2)'(dd) - (NW+2)'(nn1) - (NW+2)'(nn2);
  assign corner_ok = !nn1[NW-1] && (nn1 <= dd) && !nn2[NW-1] && (nn2 <= dd) &&
                     !n3[NW+1] && (n3 <= (NW+2)'(dd));

  assign ge1  = (r1 >= dd_r);
  assign ge2  = (r2 >= dd_r);
  assign sub1 = ge1 ? (r1 - dd_r) : r1;
  assign sub2 = ge2 ? (r2 - dd_r) : r2;

  for (genvar i = 0; i < 9; i++) begin : g_ext
    assign ex[i] = AW'(pp[i]);
  end

  for (genvar j = 0; j < 3; j++) begin : g_axis
    assign acc_next[j] = (acc[j] <<< 1) + (w1[W] ? (ex[j] - ex[6+j]) : '0) +
                         (w2[W] ? (ex[3+j] - ex[6+j]) : '0);
    assign sum[j] = acc[j] + (ex[6+j] <<< W) + RND;
    assign quo[j] = sum[j] >>> W;
    assign res[j] = (quo[j] > MAXV) ? MAXV[POS_WIDTH-1:0] :
                    (quo[j] < MINV) ? MINV[POS_WIDTH-1:0] : quo[j][POS_WIDTH-1:0];
  end

  assign out_free = !out_valid || out_ready;
  assign out_load = ((state == ST_FIN) || (state == ST_FLUSH)) && out_free && pend_valid;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        for (int i = 0; i < 9; i++) begin
          pp[i] <= q_data[i*POS_WIDTH +: POS_WIDTH];
        end
        for (int i = 0; i < 3; i++) begin
          tu[i] <= q_data[9*POS_WIDTH + (2*i)*TB +: TB];
          tv[i] <= q_data[9*POS_WIDTH + (2*i+1)*TB +: TB];
        end
      end
      ST_PROD: begin
        m1 <= NW'(ca * cd);
        m2 <= NW'(cb * cc);
      end
      ST_DET: begin
        det <= m1 - m2;
      end
      ST_N1: begin
        n1 <= NW'(ca * dx) + NW'(cb * dy);
      end
      ST_N2: begin
        n2 <= NW'(cc * dx) + NW'(cd * dy);
      end
      ST_CHECK: begin
        r1   <= {1'b0, nn1};
        r2   <= {1'b0, nn2};
        dd_r <= {1'b0, dd};
        w1   <= '0;
        w2   <= '0;
      end
      ST_DIV: begin
        r1 <= {sub1[NW-1:0], 1'b0};
        r2 <= {sub2[NW-1:0], 1'b0};
        w1 <= {w1[W-1:0], ge1};
        w2 <= {w2[W-1:0], ge2};
        for (int j = 0; j < 3; j++) begin
          acc[j] <= '0;
        end
      end
      ST_MUL: begin
        for (int j = 0; j < 3; j++) begin
          acc[j] <= acc_next[j];
        end
        w1 <= {w1[W-1:0], 1'b0};
        w2 <= {w2[W-1:0], 1'b0};
      end
      ST_FIN: begin
        if (out_free) begin
          for (int j = 0; j < 3; j++) begin
            pend_pos[j] <= res[j];
          end
          pend_k <= k;
        end
      end
      ST_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      corner_x         <= pend_pos[0];
      corner_y         <= pend_pos[1];
      corner_z         <= pend_pos[2];
      corner_index     <= pend_k;
      last_of_triangle <= (state == ST_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      k          <= 2'd0;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          state <= ST_DET;
        end
        ST_DET: begin
          k <= CORNER_TL;
          if (m1 == m2) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_N1;
          end
        end
        ST_N1: begin
          state <= ST_N2;
        end
        ST_N2: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          cnt <= '0;
          if (corner_ok) begin
            state <= ST_DIV;
          end else if (k == CORNER_BL) begin
            state <= ST_FLUSH;
          end else begin
            k     <= k + 2'd1;
            state <= ST_N1;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= ST_MUL;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_MUL: begin
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= ST_FIN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_FIN: begin
          if (out_free) begin
            pend_valid <= 1'b1;
            if (k == CORNER_BL) begin
              state <= ST_FLUSH;
            end else begin
              k     <= k + 2'd1;
              state <= ST_N1;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/texture_box_corner_locator_top.sv =====
// Top level of the texture box corner locator: configuration registers and part wiring.
//
// Vertices arrive on the in channel (valid/ready), one transfer each. Slots 0 and 1
// are held; slot 2 completes the triangle, slot 3 is dropped. A completed triangle
// whose u values touch the box span enters a two-entry queue, so the input keeps
// accepting while earlier triangles are worked on; ready falls only when it is full.
// The back part tries the four box corners in turn for each triangle with a nonzero
// determinant. It first forms the determinant, then runs the barycentric test per
// corner; for each corner inside the triangle it produces one quotient bit per cycle
// in the weight divider, then takes one weight bit per cycle in the shift-add
// interpolator. Results leave on the out channel (valid/ready), one transfer per corner
// inside the triangle; each corner is held back one slot so the final one can carry
// last_of_triangle. When the receiver stalls, the back part waits and the queue fills.
// Reset empties the queue, clears all handshakes and sets the box to the full texture
// square. Configuration writes are always taken and belong only to idle periods.
module texture_box_corner_locator_top import tbcl_pkg::*; #(
  parameter int POS_WIDTH     = 32,
  parameter int TEX_FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                vertex_slot,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_y,
  input  logic signed [POS_WIDTH-1:0] pos_z,
  input  logic [TEX_FRAC_BITS:0]    tex_u,
  input  logic [TEX_FRAC_BITS:0]    tex_v,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [POS_WIDTH-1:0] corner_x,
  output logic signed [POS_WIDTH-1:0] corner_y,
  output logic signed [POS_WIDTH-1:0] corner_z,
  output logic [1:0]                corner_index,
  output logic                      last_of_triangle,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [TEX_FRAC_BITS:0]    cfg_data
);

  localparam int ENTRY_WIDTH = 9 * POS_WIDTH + 6 * (TEX_FRAC_BITS + 1);
  localparam logic [TEX_FRAC_BITS:0] ONE = (TEX_FRAC_BITS + 1)'(1) << TEX_FRAC_BITS;

  logic [TEX_FRAC_BITS:0] box_left_u;
  logic [TEX_FRAC_BITS:0] box_top_v;
  logic [TEX_FRAC_BITS:0] box_right_u;
  logic [TEX_FRAC_BITS:0] box_bottom_v;
  logic                   q_push;
  logic [ENTRY_WIDTH-1:0] q_push_data;
  logic                   q_pop;
  logic [ENTRY_WIDTH-1:0] q_head;
  logic                   q_full;
  logic                   q_empty;
  logic                   in_accept;
  logic [POS_WIDTH-1:0]   cx, cy, cz;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;
  assign corner_x  = $signed(cx);
  assign corner_y  = $signed(cy);
  assign corner_z  = $signed(cz);

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left_u   <= '0;
      box_top_v    <= '0;
      box_right_u  <= ONE;
      box_bottom_v <= ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEFT_U:   box_left_u   <= cfg_data;
        CFG_TOP_V:    box_top_v    <= cfg_data;
        CFG_RIGHT_U:  box_right_u  <= cfg_data;
        CFG_BOTTOM_V: box_bottom_v <= cfg_data;
        default:      box_left_u   <= box_left_u;
      endcase
    end
  end

  tbcl_front #(
    .POS_WIDTH     (POS_WIDTH),
    .TEX_FRAC_BITS (TEX_FRAC_BITS),
    .ENTRY_WIDTH   (ENTRY_WIDTH)
  ) u_front (
    .clk         (clk),
    .accept      (in_accept),
    .vertex_slot (vertex_slot),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .tex_u       (tex_u),
    .tex_v       (tex_v),
    .box_left_u  (box_left_u),
    .box_right_u (box_right_u),
    .push        (q_push),
    .push_data   (q_push_data)
  );

  tbcl_queue #(
    .DATA_WIDTH (ENTRY_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  tbcl_back #(
    .POS_WIDTH     (POS_WIDTH),
    .TEX_FRAC_BITS (TEX_FRAC_BITS),
    .ENTRY_WIDTH   (ENTRY_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_data           (q_head),
    .q_pop            (q_pop),
    .box_left_u       (box_left_u),
    .box_top_v        (box_top_v),
    .box_right_u      (box_right_u),
    .box_bottom_v     (box_bottom_v),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .corner_x         (cx),
    .corner_y         (cy),
    .corner_z         (cz),
    .corner_index     (corner_index),
    .last_of_triangle (last_of_triangle)
  );

endmodule
